// ===== rtl/dtt_pkg.sv =====
// Package for the deadline timer table: widths, command codes and result kinds.
// Used by deadline_timer_table_core.
package dtt_pkg;
  localparam int unsigned NumTimers = 16;
  localparam int unsigned IdW       = 4;
  localparam int unsigned TimeW     = 48;
  localparam int unsigned DurW      = 32;
  localparam int unsigned StampW    = 32;

  typedef enum logic [1:0] {
    CmdStart = 2'd0,
    CmdStop  = 2'd1,
    CmdTick  = 2'd2,
    CmdQuery = 2'd3
  } cmd_e;

  localparam logic KindExpire = 1'b0;
  localparam logic KindQuery  = 1'b1;
endpackage

// ===== rtl/deadline_timer_table_core.sv =====
// Deadline timer table: 16 slots with deadline and start stamp in one synchronous memory.
// Uses dtt_pkg.
// Start and stop complete in their accept cycle. A query scans all slots, then registers its
// result; the next input is taken once the block is back in idle. A tick does one scan per
// reported slot plus a final empty scan (none after a 16th report), all on the single read
// port of the slot memory. Reset clears run marks, tick count and stamp count.
module deadline_timer_table_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [3:0]  timer_id_i,
  input  logic [31:0] duration_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        result_kind_o,
  output logic [3:0]  expired_id_o,
  output logic [31:0] time_left_o,
  output logic        none_running_o,
  output logic        last_o
);

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StScan = 5'b00010,
    StEval = 5'b00100,
    StEmit = 5'b01000,
    StWait = 5'b10000
  } state_e;

  localparam int unsigned EntW = dtt_pkg::TimeW + dtt_pkg::StampW;

  logic [EntW-1:0] mem_q [dtt_pkg::NumTimers];
  logic [EntW-1:0] rdata_q;

  state_e state_q, state_d;
  logic [dtt_pkg::NumTimers-1:0] run_q, run_d;
  logic [dtt_pkg::TimeW-1:0]  now_q, now_d;
  logic [dtt_pkg::StampW-1:0] stamp_q, stamp_d;
  logic [1:0] cmd_q, cmd_d;
  logic [dtt_pkg::IdW:0] ridx_q, ridx_d;   // read address, one past end = done
  logic [dtt_pkg::IdW-1:0] eidx_q, eidx_d; // index of data in rdata_q
  logic rvld_q, rvld_d;
  logic best_v_q, best_v_d;
  logic [dtt_pkg::IdW-1:0] best_id_q, best_id_d;
  logic [dtt_pkg::TimeW-1:0] best_rem_q, best_rem_d;
  logic [dtt_pkg::StampW-1:0] best_age_q, best_age_d;
  logic [4:0] nrep_q, nrep_d;
  logic pend_v_q, pend_v_d;
  logic [dtt_pkg::IdW-1:0] pend_id_q, pend_id_d;
  logic ov_q, ov_d, okind_q, okind_d, onone_q, onone_d, olast_q, olast_d;
  logic [dtt_pkg::IdW-1:0] oid_q, oid_d;
  logic [31:0] oleft_q, oleft_d;

  logic we;
  logic [dtt_pkg::IdW-1:0] waddr, raddr;
  logic [EntW-1:0] wdata;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  logic [dtt_pkg::TimeW-1:0] e_rem, e_key, b_key;
  logic [dtt_pkg::StampW-1:0] e_age;
  logic e_due, e_cand, e_better, in_acc, out_acc;

  assign e_rem = rdata_q[EntW-1 -: dtt_pkg::TimeW] - now_q;
  assign e_age = stamp_q - rdata_q[dtt_pkg::StampW-1:0];
  assign e_due = (e_rem == '0) || e_rem[dtt_pkg::TimeW-1];
  assign e_key = {~e_rem[dtt_pkg::TimeW-1], e_rem[dtt_pkg::TimeW-2:0]};
  assign b_key = {~best_rem_q[dtt_pkg::TimeW-1], best_rem_q[dtt_pkg::TimeW-2:0]};
  assign e_cand = rvld_q && run_q[eidx_q] &&
                  ((cmd_q == dtt_pkg::CmdQuery) || e_due);
  assign e_better = !best_v_q || (e_key < b_key) ||
                    ((e_key == b_key) && (e_age > best_age_q));

  assign in_ready_o = (state_q == StIdle) && !pend_v_q;
  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = ov_q && out_ready_i;
  assign out_valid_o    = ov_q;
  assign result_kind_o  = okind_q;
  assign expired_id_o   = oid_q;
  assign time_left_o    = oleft_q;
  assign none_running_o = onone_q;
  assign last_o         = olast_q;

  always_comb begin
    state_d = state_q; run_d = run_q; now_d = now_q; stamp_d = stamp_q;
    cmd_d = cmd_q; ridx_d = ridx_q; eidx_d = eidx_q; rvld_d = 1'b0;
    best_v_d = best_v_q; best_id_d = best_id_q; best_rem_d = best_rem_q;
    best_age_d = best_age_q; nrep_d = nrep_q; pend_v_d = pend_v_q; pend_id_d = pend_id_q;
    ov_d = ov_q; okind_d = okind_q; oid_d = oid_q; oleft_d = oleft_q;
    onone_d = onone_q; olast_d = olast_q;
    we = 1'b0; waddr = timer_id_i;
    wdata = {now_q + {16'd0, duration_i}, stamp_q};
    raddr = ridx_q[dtt_pkg::IdW-1:0];

    if (out_acc) ov_d = 1'b0;

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          cmd_d = command_i;
          case (dtt_pkg::cmd_e'(command_i))
            dtt_pkg::CmdStart: begin
              we = 1'b1;
              run_d[timer_id_i] = 1'b1;
              stamp_d = stamp_q + 1'b1;
            end
            dtt_pkg::CmdStop: run_d[timer_id_i] = 1'b0;
            dtt_pkg::CmdTick: begin
              now_d = now_q + 1'b1;
              nrep_d = '0;
              ridx_d = '0; best_v_d = 1'b0; state_d = StScan;
            end
            default: begin
              ridx_d = '0; best_v_d = 1'b0; state_d = StScan;
            end
          endcase
        end
      end
      StScan: begin
        if (e_cand && e_better) begin
          best_v_d = 1'b1; best_id_d = eidx_q; best_rem_d = e_rem; best_age_d = e_age;
        end
        if (ridx_q == dtt_pkg::NumTimers) begin
          state_d = StEval;
        end else begin
          rvld_d = 1'b1;
          eidx_d = ridx_q[dtt_pkg::IdW-1:0];
          ridx_d = ridx_q + 1'b1;
        end
      end
      StEval: begin
        // last entry was taken in the final scan cycle; rvld_q is low here
        if (e_cand && e_better) begin
          best_v_d = 1'b1; best_id_d = eidx_q; best_rem_d = e_rem; best_age_d = e_age;
        end
        state_d = StEmit;
      end
      StEmit: begin
        if (cmd_q == dtt_pkg::CmdQuery) begin
          if (!ov_q || out_acc) begin
            ov_d = 1'b1; okind_d = dtt_pkg::KindQuery; oid_d = '0;
            onone_d = !best_v_q; olast_d = 1'b1;
            oleft_d = (!best_v_q || best_rem_q[dtt_pkg::TimeW-1]) ? '0 : best_rem_q[31:0];
            state_d = StIdle;
          end
        end else if (!best_v_q) begin
          // no more due slots: mark the held report as last
          if (pend_v_q) begin
            if (!ov_q || out_acc) begin
              ov_d = 1'b1; okind_d = dtt_pkg::KindExpire; oid_d = pend_id_q;
              oleft_d = '0; onone_d = 1'b0; olast_d = 1'b1;
              pend_v_d = 1'b0; state_d = StIdle;
            end
          end else begin
            state_d = StIdle;
          end
        end else if (!pend_v_q || !ov_q || out_acc) begin
          // another due slot follows, so the held report is not the last one
          if (pend_v_q) begin
            ov_d = 1'b1; okind_d = dtt_pkg::KindExpire; oid_d = pend_id_q;
            oleft_d = '0; onone_d = 1'b0; olast_d = 1'b0;
          end
          run_d[best_id_q] = 1'b0;
          pend_v_d = 1'b1; pend_id_d = best_id_q;
          nrep_d = nrep_q + 1'b1;
          if (nrep_q == 5'd15) begin
            state_d = StWait;
          end else begin
            ridx_d = '0; best_v_d = 1'b0; state_d = StScan;
          end
        end
      end
      StWait: begin
        // report limit reached: the held report is the last one
        if (!ov_q || out_acc) begin
          ov_d = 1'b1; okind_d = dtt_pkg::KindExpire; oid_d = pend_id_q;
          oleft_d = '0; onone_d = 1'b0; olast_d = 1'b1;
          pend_v_d = 1'b0; state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; run_q <= '0; now_q <= '0; stamp_q <= '0;
      rvld_q <= 1'b0; pend_v_q <= 1'b0; ov_q <= 1'b0; best_v_q <= 1'b0;
      cmd_q <= '0; ridx_q <= '0; nrep_q <= '0;
    end else begin
      state_q <= state_d; run_q <= run_d; now_q <= now_d; stamp_q <= stamp_d;
      rvld_q <= rvld_d; pend_v_q <= pend_v_d; ov_q <= ov_d; best_v_q <= best_v_d;
      cmd_q <= cmd_d; ridx_q <= ridx_d; nrep_q <= nrep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    eidx_q <= eidx_d; best_id_q <= best_id_d; best_rem_q <= best_rem_d;
    best_age_q <= best_age_d; pend_id_q <= pend_id_d;
    okind_q <= okind_d; oid_q <= oid_d; oleft_q <= oleft_d;
    onone_q <= onone_d; olast_q <= olast_d;
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for deadline_timer_table_core: directed table, sixteen-due ticks, then random commands,
// checked against an in-bench timer-table predictor. Depends on dtt_pkg and the core.
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    logic        kind;
    logic [3:0]  id;
    logic [31:0] left;
    logic        none;
    logic        last;
  } report_t;

  typedef struct {
    dtt_pkg::cmd_e cmd;
    logic [3:0]  id;
    logic [31:0] dur;
    bit          has_fixed;
    report_t     fixed;
  } row_t;

  localparam int unsigned WdogLimit = 200000;
  localparam int unsigned DrainCycles = 600;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  command_i = dtt_pkg::CmdStart;
  logic [3:0]  timer_id_i = '0;
  logic [31:0] duration_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        result_kind_o;
  logic [3:0]  expired_id_o;
  logic [31:0] time_left_o;
  logic        none_running_o;
  logic        last_o;

  deadline_timer_table_core dut (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [47:0] now_q;
  logic [47:0] due_q [dtt_pkg::NumTimers];
  logic        armed_q [dtt_pkg::NumTimers];
  logic [31:0] stamp_q [dtt_pkg::NumTimers];
  logic [31:0] stamp_ctr_q;

  report_t pending_reports[$];
  int      err_cnt = 0;
  int      idle_cnt = 0;
  bit      hold_rx = 1'b0;
  bit      calm = 1'b0;
  bit      done_stim = 1'b0;

  function automatic logic [47:0] left_of(int i);
    return due_q[i] - now_q;
  endfunction

  function automatic bit ahead(int a, int b);
    logic [47:0] ka, kb;
    ka = left_of(a) ^ 48'h8000_0000_0000;
    kb = left_of(b) ^ 48'h8000_0000_0000;
    if (ka != kb) return ka < kb;
    return (stamp_ctr_q - stamp_q[a]) > (stamp_ctr_q - stamp_q[b]);
  endfunction

  function automatic int first_armed(bit due_only);
    int best;
    logic [47:0] r;
    best = -1;
    for (int i = 0; i < dtt_pkg::NumTimers; i++) begin
      r = left_of(i);
      if (!armed_q[i]) continue;
      if (due_only && !(r == 0 || r[47])) continue;
      if (best < 0 || ahead(i, best)) best = i;
    end
    return best;
  endfunction

  task automatic predict_timers(dtt_pkg::cmd_e c, logic [3:0] id, logic [31:0] d);
    report_t rep;
    int s, n;
    logic [47:0] r;
    n = 0;
    case (c)
      dtt_pkg::CmdStart: begin
        due_q[id] = now_q + {16'd0, d};
        stamp_q[id] = stamp_ctr_q;
        stamp_ctr_q++;
        armed_q[id] = 1'b1;
      end
      dtt_pkg::CmdStop: armed_q[id] = 1'b0;
      dtt_pkg::CmdTick: begin
        now_q++;
        while (n < 16) begin
          s = first_armed(1'b1);
          if (s < 0) break;
          armed_q[s] = 1'b0;
          rep = '{dtt_pkg::KindExpire, 4'(s), 32'd0, 1'b0, 1'b0};
          pending_reports.push_back(rep);
          n++;
        end
        if (n > 0) pending_reports[$].last = 1'b1;
      end
      default: begin
        s = first_armed(1'b0);
        if (s < 0) rep = '{dtt_pkg::KindQuery, 4'd0, 32'd0, 1'b1, 1'b1};
        else begin
          r = left_of(s);
          rep = '{dtt_pkg::KindQuery, 4'd0, (r == 0 || r[47]) ? 32'd0 : r[31:0], 1'b0, 1'b1};
        end
        pending_reports.push_back(rep);
      end
    endcase
  endtask

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    err_cnt++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    report_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{result_kind_o, expired_id_o, time_left_o, none_running_o, last_o};
      if (pending_reports.size() == 0) report_mismatch("unexpected result");
      else begin
        if (got.kind !== pending_reports[0].kind) report_mismatch("result_kind");
        if (got.id !== pending_reports[0].id) report_mismatch("expired_id");
        if (got.left !== pending_reports[0].left) report_mismatch("time_left");
        if (got.none !== pending_reports[0].none) report_mismatch("none_running");
        if (got.last !== pending_reports[0].last) report_mismatch("last");
        void'(pending_reports.pop_front());
      end
    end
  end

  // receiver side
  always @(posedge clk_i) begin
    if (hold_rx) out_ready_i <= 1'b0;
    else if (calm) out_ready_i <= 1'b1;
    else out_ready_i <= ($urandom_range(99) >= 12);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cnt <= 0;
    else if (rst_ni) idle_cnt <= idle_cnt + 1;
    if (idle_cnt > WdogLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // valid drops only while idling, so one edge never sees two writes to it
  task automatic send_item(dtt_pkg::cmd_e c, logic [3:0] id, logic [31:0] d);
    if (!calm) begin
      while ($urandom_range(99) < 12) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    command_i <= c;
    timer_id_i <= id;
    duration_i <= d;
    do @(posedge clk_i); while (!in_ready_o);
    predict_timers(c, id, d);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
  endtask

  row_t directed_rows[$];

  task automatic add_row(dtt_pkg::cmd_e c, logic [3:0] id, logic [31:0] d,
                         bit fx = 0, report_t f = '0);
    row_t r;
    r.cmd = c; r.id = id; r.dur = d; r.has_fixed = fx; r.fixed = f;
    directed_rows.push_back(r);
  endtask

  function automatic logic [31:0] rand_dur();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF - $urandom_range(3);
      2: return $urandom;
      default: return $urandom_range(8);
    endcase
  endfunction

  initial begin
    dtt_pkg::cmd_e c;
    int   sent;
    now_q = '0; stamp_ctr_q = '0;
    for (int i = 0; i < dtt_pkg::NumTimers; i++) begin
      armed_q[i] = 1'b0; due_q[i] = '0; stamp_q[i] = '0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty query, extremes, zero duration, ties, eight due in one tick, stop idle slot
    add_row(dtt_pkg::CmdQuery, 4'd0, 32'd0, 1,
            '{dtt_pkg::KindQuery, 4'd0, 32'd0, 1'b1, 1'b1});
    add_row(dtt_pkg::CmdTick, 4'd0, 32'd0);
    add_row(dtt_pkg::CmdStop, 4'd3, 32'd0);
    add_row(dtt_pkg::CmdStart, 4'd15, 32'hFFFF_FFFF);
    add_row(dtt_pkg::CmdQuery, 4'd0, 32'd0, 1,
            '{dtt_pkg::KindQuery, 4'd0, 32'hFFFF_FFFF, 1'b0, 1'b1});
    add_row(dtt_pkg::CmdStart, 4'd0, 32'd0);
    add_row(dtt_pkg::CmdQuery, 4'd0, 32'd0, 1,
            '{dtt_pkg::KindQuery, 4'd0, 32'd0, 1'b0, 1'b1});
    add_row(dtt_pkg::CmdStart, 4'd5, 32'd1);
    add_row(dtt_pkg::CmdStart, 4'd2, 32'd1);
    add_row(dtt_pkg::CmdStart, 4'd5, 32'd1);
    add_row(dtt_pkg::CmdTick, 4'd0, 32'd0);
    add_row(dtt_pkg::CmdStop, 4'd15, 32'd0);
    add_row(dtt_pkg::CmdStop, 4'd15, 32'd0);
    for (int i = 0; i < 8; i++) add_row(dtt_pkg::CmdStart, 4'(15 - i), 32'd0);
    add_row(dtt_pkg::CmdStart, 4'd7, 32'h8000_0000);
    add_row(dtt_pkg::CmdTick, 4'd0, 32'd0);
    add_row(dtt_pkg::CmdQuery, 4'd0, 32'd0);
    foreach (directed_rows[k]) begin
      send_item(directed_rows[k].cmd, directed_rows[k].id, directed_rows[k].dur);
      if (directed_rows[k].has_fixed) begin
        if (pending_reports.size() == 0 || pending_reports[$] != directed_rows[k].fixed)
          report_mismatch("directed row expectation");
      end
    end

    // sixteen due at once, as many as one tick can report, with the receiver held off
    wait_drained();
    for (int i = 0; i < dtt_pkg::NumTimers; i++) send_item(dtt_pkg::CmdStart, 4'(i), 32'd0);
    fork
      begin
        hold_rx = 1'b1;
        repeat (400) @(posedge clk_i);
        hold_rx = 1'b0;
      end
    join_none
    for (int i = 0; i < 4; i++) send_item(dtt_pkg::CmdTick, 4'd0, 32'd0);
    wait_drained();
    send_item(dtt_pkg::CmdQuery, 4'd0, 32'd0);

    sent = 0;
    while (sent < 380) begin
      calm = (sent >= 150 && sent < 210);
      if ($urandom_range(9) == 0) begin
        // burst arming of many slots with short times
        for (int i = 0; i < 6; i++)
          send_item(dtt_pkg::CmdStart, 4'($urandom), $urandom_range(3));
        sent += 6;
        continue;
      end
      case ($urandom_range(9))
        0, 1, 2: c = dtt_pkg::CmdStart;
        3: c = dtt_pkg::CmdStop;
        4, 5, 6, 7: c = dtt_pkg::CmdTick;
        default: c = dtt_pkg::CmdQuery;
      endcase
      send_item(c, 4'($urandom), rand_dur());
      sent++;
    end
    calm = 1'b0;

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0 && pending_reports.size() == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/dtt_pkg.sv
rtl/deadline_timer_table_core.sv
tb/sv/tb_top.sv
